@@ design/mlfq_pkg.sv @@
// shared types and constants of the multilevel feedback queue scheduler
`timescale 1ns / 1ps
`default_nettype none

package mlfq_pkg;

  localparam int OPCODE_W    = 2;
  localparam int TID_W       = 4;
  localparam int ELAPSED_W   = 10;
  localparam int SLICE_W     = 10;
  localparam int RUN_LEVEL_W = 2;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 10'd25;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_YIELD  = 2'd2,
    OP_EXIT   = 2'd3
  } op_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

`default_nettype wire

@@ design/mlfq_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module mlfq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/mlfq_level_fifo.sv @@
// one ready queue level: ram fifo with a show-ahead head word
`timescale 1ns / 1ps
`default_nettype none

module mlfq_level_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mlfq_pkg::fifo_ctl_t      ctl,
  input  logic [$clog2(DEPTH)-1:0] push_id,
  output logic [$clog2(DEPTH)-1:0] head_id,
  output mlfq_pkg::fifo_stat_t     stat
);
  import mlfq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] ram_rdata;
  logic             byp_hit;
  logic [PTR_W-1:0] byp_data;

  always_comb begin
    head_next = head;
    tail_next = tail;
    if (ctl.pop) begin
      head_next = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
    end
    if (ctl.push) begin
      tail_next = (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
    end
    count_next = count + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      byp_hit <= 1'b0;
    end else begin
      head    <= head_next;
      tail    <= tail_next;
      count   <= count_next;
      // write landing on the slot being read: ram returns the old word
      byp_hit <= ctl.push && (tail == head_next);
    end
    byp_data <= push_id;
  end

  // read address is the next head pointer so the registered head word is ready when head moves
  mlfq_ram #(
    .WIDTH (PTR_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (tail),
    .wdata (push_id),
    .raddr (head_next),
    .rdata (ram_rdata)
  );

  assign head_id    = byp_hit ? byp_data : ram_rdata;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));

endmodule

`default_nettype wire

@@ design/mlfq_thread_scheduler_unit.sv @@
// top level of the multilevel feedback queue thread scheduler
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------------
//  command   | start / busy       | opcode, thread_id, elapsed
//  result    | done (1-cycle)     | running_valid, running_id, running_level,
//            |                    | switched, error
//  config    | cfg_we             | cfg_wdata (base slice)
//
// one command word is taken every cycle while busy is low; the accepting edge loads
// the input register, one pass of dispatch logic fills the result register, and the
// receiver takes the result word from the result register
// the single pass holds a priority pick over the level counts, one fifo pop
// and one fifo push; each level ram keeps its head word prefetched
// busy is high during synchronous reset and for the first cycle after it
// the receiver cannot stall: done is a one-cycle strobe
`timescale 1ns / 1ps
`default_nettype none

module mlfq_thread_scheduler_unit #(
  parameter int LEVELS      = 4,
  parameter int MAX_THREADS = 16,
  parameter int COUNT_BITS  = 14
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [mlfq_pkg::OPCODE_W-1:0]    opcode,
  input  logic [mlfq_pkg::TID_W-1:0]       thread_id,
  input  logic [mlfq_pkg::ELAPSED_W-1:0]   elapsed,
  input  logic                             cfg_we,
  input  logic [mlfq_pkg::SLICE_W-1:0]     cfg_wdata,
  output logic                             done,
  output logic                             running_valid,
  output logic [mlfq_pkg::TID_W-1:0]       running_id,
  output logic [mlfq_pkg::RUN_LEVEL_W-1:0] running_level,
  output logic                             switched,
  output logic                             error
);
  import mlfq_pkg::*;

  localparam int ID_W      = $clog2(MAX_THREADS);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int SL_W      = SLICE_W + LEVELS - 1;
  localparam int CMP_W     = (COUNT_BITS > SL_W) ? COUNT_BITS : SL_W;

  // input register
  logic                 in_valid;
  op_t                  in_op;
  logic [TID_W-1:0]     in_tid;
  logic [ELAPSED_W-1:0] in_elapsed;

  // scheduler state
  logic [SLICE_W-1:0]     base_slice;
  logic                   cur_valid;
  logic [ID_W-1:0]        cur_id;
  logic [LVL_W-1:0]       cur_level;
  logic [COUNT_BITS-1:0]  run_counter;
  logic [MAX_THREADS-1:0] thread_ready;

  logic                   cur_valid_next;
  logic [ID_W-1:0]        cur_id_next;
  logic [LVL_W-1:0]       cur_level_next;
  logic [COUNT_BITS-1:0]  run_counter_next;
  logic [MAX_THREADS-1:0] thread_ready_next;

  // level fifos
  fifo_ctl_t  ctl     [LEVELS];
  fifo_stat_t stat    [LEVELS];
  logic [ID_W-1:0] head_id [LEVELS];

  // dispatch datapath
  logic                  found;
  logic [LVL_W-1:0]      sel_lvl;
  logic [ID_W-1:0]       next_id;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] sat;
  logic [SL_W-1:0]       slice;
  logic                  slice_hit;
  logic [LVL_W-1:0]      demote_lvl;
  logic [ID_W-1:0]       tid_id;
  logic                  tid_oob;
  logic                  do_pop;
  logic                  want_push;
  logic                  do_push;
  logic [LVL_W-1:0]      push_lvl;
  logic [ID_W-1:0]       push_id;
  logic                  sw;
  logic                  err;

  // input register; nothing is accepted in the cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      in_valid <= 1'b0;
    end else begin
      busy     <= 1'b0;
      in_valid <= start && !busy;
    end
    in_op      <= op_t'(opcode);
    in_tid     <= thread_id;
    in_elapsed <= elapsed;
  end

  // level fifos, one ram each
  for (genvar l = 0; l < LEVELS; l++) begin : g_level
    assign ctl[l].pop  = do_pop && (sel_lvl == LVL_W'(l));
    assign ctl[l].push = do_push && (push_lvl == LVL_W'(l));

    mlfq_level_fifo #(
      .DEPTH (MAX_THREADS)
    ) u_fifo (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl[l]),
      .push_id (push_id),
      .head_id (head_id[l]),
      .stat    (stat[l])
    );
  end

  // lowest-numbered non-empty level wins
  always_comb begin
    found   = 1'b0;
    sel_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (!stat[l].empty) begin
        found   = 1'b1;
        sel_lvl = LVL_W'(l);
      end
    end
  end

  assign next_id = head_id[sel_lvl];

  // saturating run counter and slice compare
  assign sum        = {1'b0, run_counter} + (COUNT_BITS + 1)'(in_elapsed);
  assign sat        = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  assign slice      = SL_W'(base_slice) << cur_level;
  assign slice_hit  = CMP_W'(sat) >= CMP_W'(slice);
  // lowest level wraps around to the top
  assign demote_lvl = (cur_level == LVL_W'(LEVELS - 1)) ? '0 : cur_level + 1'b1;

  assign tid_id  = ID_W'(in_tid);
  assign tid_oob = int'(in_tid) >= MAX_THREADS;

  always_comb begin
    cur_valid_next   = cur_valid;
    cur_id_next      = cur_id;
    cur_level_next   = cur_level;
    run_counter_next = run_counter;
    do_pop           = 1'b0;
    want_push        = 1'b0;
    push_lvl         = cur_level;
    push_id          = cur_id;
    err              = 1'b0;

    if (in_valid) begin
      case (in_op)
        OP_TICK: begin
          if (cur_valid) begin
            run_counter_next = sat;
            if (slice_hit && found) begin
              do_pop    = 1'b1;
              want_push = 1'b1;
              push_lvl  = demote_lvl;
            end
          end else begin
            do_pop = found;
          end
        end
        OP_CREATE: begin
          if (tid_oob || thread_ready[tid_id] || (cur_valid && cur_id == tid_id) ||
              stat[0].full) begin
            err = 1'b1;
          end else begin
            want_push = 1'b1;
            push_lvl  = '0;
            push_id   = tid_id;
          end
        end
        OP_YIELD: begin
          do_pop    = found;
          want_push = found && cur_valid;
        end
        OP_EXIT: begin
          cur_valid_next   = 1'b0;
          cur_id_next      = '0;
          cur_level_next   = '0;
          run_counter_next = '0;
          do_pop           = found;
        end
        default: begin
          err = 1'b0;
        end
      endcase
    end

    // the popped thread takes over at the level it was queued on
    if (do_pop) begin
      cur_valid_next   = 1'b1;
      cur_id_next      = next_id;
      cur_level_next   = sel_lvl;
      run_counter_next = '0;
    end
    sw = do_pop;

    // a full target level can only take the old thread if it is popped now
    do_push = want_push && (!stat[push_lvl].full || (do_pop && push_lvl == sel_lvl));
  end

  // ready flags follow the fifo traffic
  always_comb begin
    thread_ready_next = thread_ready;
    if (do_pop) begin
      thread_ready_next[next_id] = 1'b0;
    end
    if (do_push) begin
      thread_ready_next[push_id] = 1'b1;
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_slice   <= SLICE_RESET;
      cur_valid    <= 1'b1;
      cur_id       <= '0;
      cur_level    <= '0;
      run_counter  <= '0;
      thread_ready <= '0;
      done         <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_slice <= cfg_wdata;
      end
      cur_valid    <= cur_valid_next;
      cur_id       <= cur_id_next;
      cur_level    <= cur_level_next;
      run_counter  <= run_counter_next;
      thread_ready <= thread_ready_next;
      done         <= in_valid;
    end
    running_valid <= cur_valid_next;
    running_id    <= TID_W'(cur_id_next);
    running_level <= RUN_LEVEL_W'(cur_level_next);
    switched      <= sw;
    error         <= err;
  end

  // every accepted word yields its result through the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted command word produced no result");

  // a dispatch always leaves a thread running
  a_switch_runs: assert property (@(posedge clk) disable iff (rst)
    (done && switched) |-> running_valid)
    else $error("switch reported with no running thread");

  // a rejected create never dispatches
  a_error_no_switch: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> !switched)
    else $error("rejected create caused a dispatch");

  // idle cpu reports zero id and level
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !running_valid) |-> (running_id == '0 && running_level == '0))
    else $error("nonzero id or level while nothing runs");

endmodule

`default_nettype wire
